### rtl/assert_macros.svh
// assert_macros.svh: assertion shorthands for the FIR checker.
// Needs nothing else; taken in by `include in files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General concurrent assertion, sampled on the rising clock, off during reset.
`define FIR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A signal holds its value in the cycle after cond is seen.
`define FIR_ASSERT_HOLD(label, clk, rst, cond, sig, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> $stable(sig)) \
      else $error(msg);

`endif

### rtl/fir_pkg.sv
// fir_pkg: constants, coefficient table, sequencer states and helpers
// for the 27-tap FIR core. No dependencies.
`default_nettype none

package fir_pkg;

   localparam int TAP_COUNT    = 27;
   localparam int MAX_TAPS     = 64;
   localparam int TAP_IDX_W    = 6;
   localparam int SAMPLE_WIDTH = 16;
   localparam int COEF_WIDTH   = 16;
   localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEF_WIDTH;

   // APB register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic [0:0] REG_FILTER_ENABLE = 1'b0;

   // Q1.15 taps, newest sample first
   localparam logic signed [COEF_WIDTH-1:0] COEF_ROM [0:MAX_TAPS-1] = '{
      0:  -16'sd272,  1:  16'sd449,   2:  16'sd266,   3:  -16'sd540,
      4:  16'sd55,    5:  -16'sd227,  6:  16'sd1029,  7:  16'sd745,
      8:  -16'sd3927, 9:  16'sd1699,  10: 16'sd5616,  11: -16'sd6594,
      12: -16'sd2766, 13: 16'sd9228,  14: -16'sd2766, 15: -16'sd6594,
      16: 16'sd5616,  17: 16'sd1699,  18: -16'sd3927, 19: 16'sd745,
      20: 16'sd1029,  21: -16'sd227,  22: 16'sd55,    23: -16'sd540,
      24: 16'sd266,   25: 16'sd449,   26: -16'sd272,
      default: 16'sd0
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_MAC,
      ST_DRAIN,
      ST_DONE
   } fir_state_type;

   function automatic int addr_width(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   function automatic logic signed [COEF_WIDTH-1:0] coef_at(
      input logic [TAP_IDX_W-1:0] idx);
      return COEF_ROM[idx];
   endfunction

endpackage

`default_nettype wire

### rtl/fir_ram.sv
// fir_ram: generic single-write, single-read RAM with registered read data.
// Uses fir_pkg::addr_width for its address width.
`default_nettype none

module fir_ram #(
   parameter int DATA_W = fir_pkg::SAMPLE_WIDTH,
   parameter int DEPTH  = fir_pkg::TAP_COUNT
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [fir_pkg::addr_width(DEPTH)-1:0]   wr_addr,
   input  wire logic [DATA_W-1:0]                       wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [fir_pkg::addr_width(DEPTH)-1:0]   rd_addr,
   output      logic [DATA_W-1:0]                       rd_data
);

   logic [DATA_W-1:0] mem_ff [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/fir_lowpass_27tap_core.sv
// fir_lowpass_27tap_core: 27-tap symmetric low-pass FIR, Q4.12 in and out.
// Depends on fir_pkg and fir_ram (sample history memory).
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------
//   req     | in        | req_valid / req_stall | req_sample_in  (s16 Q4.12)
//   rsp     | out       | rsp_valid / rsp_stall | rsp_sample_out (s16 Q4.12)
//   csr     | in/out    | APB, pready tied high | filter_enable at byte 0
//
// One word at a time. Filtered word: ST_WRITE stores it, ST_MAC runs the single
// multiply-accumulate walking the history memory one tap per cycle, ST_DRAIN
// empties the pipeline and ST_DONE offers the result; the next word is taken once
// back in ST_IDLE. Bypassed word: ST_IDLE goes straight to ST_DONE, which offers it.
// Reset (synchronous) clears the sequencer, write pointer and per-slot valid bits.
// rsp_stall holds a finished word; the next one is taken in and parks in ST_DONE.
`default_nettype none

module fir_lowpass_27tap_core #(
   parameter int TAP_COUNT = fir_pkg::TAP_COUNT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input samples
   input  wire logic                                   req_valid,
   output      logic                                   req_stall,
   input  wire logic signed [fir_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   // filtered samples
   output      logic                                   rsp_valid,
   input  wire logic                                   rsp_stall,
   output      logic signed [fir_pkg::SAMPLE_WIDTH-1:0] rsp_sample_out,
   // register port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic [fir_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  wire logic [fir_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output      logic [fir_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output      logic                                   csr_pready
);

   localparam int SW     = fir_pkg::SAMPLE_WIDTH;
   localparam int CW     = fir_pkg::COEF_WIDTH;
   localparam int PW     = fir_pkg::PROD_WIDTH;
   localparam int PTR_W  = fir_pkg::addr_width(TAP_COUNT);
   localparam int ACC_W  = PW + PTR_W;
   localparam int TIW    = fir_pkg::TAP_IDX_W;
   localparam int FRAC   = CW - 1;
   localparam logic [PTR_W-1:0] LAST_TAP = PTR_W'(TAP_COUNT - 1);
   localparam logic signed [ACC_W:0] ROUND_ADD = (ACC_W + 1)'(1) <<< (CW - 2);
   localparam logic signed [ACC_W:0] SAT_HI = (ACC_W + 1)'((2 ** (SW - 1)) - 1);
   localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - (ACC_W + 1)'(1);

   // ---------------- registers ----------------
   fir_pkg::fir_state_type state_ff, state_in;

   logic                    enable_ff,   enable_in;
   logic [PTR_W-1:0]        wp_ff,       wp_in;       // next history slot
   logic [TAP_COUNT-1:0]    valid_ff,    valid_in;    // slot written since reset
   logic [PTR_W-1:0]        rd_addr_ff,  rd_addr_in;  // walks back from newest
   logic [PTR_W-1:0]        iss_ff,      iss_in;      // tap being issued
   logic signed [SW-1:0]    smp_ff,      smp_in;
   logic                    bypass_ff,   bypass_in;

   // MAC pipeline: read -> multiply -> accumulate
   logic                    d1_vld_ff,   d1_vld_in;
   logic [PTR_W-1:0]        d1_tap_ff,   d1_tap_in;
   logic                    d1_hit_ff,   d1_hit_in;
   logic                    d2_vld_ff,   d2_vld_in;
   logic signed [PW-1:0]    prod_ff,     prod_in;
   logic signed [ACC_W-1:0] acc_ff,      acc_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SW-1:0]    rsp_data_ff,  rsp_data_in;

   // ---------------- history memory ----------------
   logic              ram_we;
   logic              ram_re;
   logic [SW-1:0]     ram_rd_data;

   fir_ram #(
      .DATA_W (SW),
      .DEPTH  (TAP_COUNT)
   ) u_hist (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wp_ff),
      .wr_data (smp_ff),
      .rd_en   (ram_re),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rd_data)
   );

   // ---------------- datapath helpers ----------------
   logic signed [SW-1:0]    operand;
   logic signed [CW-1:0]    coef;
   logic signed [ACC_W:0]   rnd_sum;
   logic signed [ACC_W:0]   rnd_shift;
   logic signed [SW-1:0]    sat_result;
   logic                    csr_wr;

   // never-written slots read as zero
   assign operand = d1_hit_ff ? $signed(ram_rd_data) : '0;
   assign coef    = fir_pkg::coef_at(TIW'(d1_tap_ff));

   // round half up, drop 15 fraction bits, clamp to Q4.12
   assign rnd_sum   = {acc_ff[ACC_W-1], acc_ff} + ROUND_ADD;
   assign rnd_shift = rnd_sum >>> FRAC;

   always_comb begin
      if (rnd_shift > SAT_HI) begin
         sat_result = SAT_HI[SW-1:0];
      end else if (rnd_shift < SAT_LO) begin
         sat_result = SAT_LO[SW-1:0];
      end else begin
         sat_result = rnd_shift[SW-1:0];
      end
   end

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         fir_pkg::REG_FILTER_ENABLE: csr_prdata[0] = enable_ff;
         default:                    csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fir_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      enable_in    = enable_ff;
      wp_in        = wp_ff;
      valid_in     = valid_ff;
      rd_addr_in   = rd_addr_ff;
      iss_in       = iss_ff;
      smp_in       = smp_ff;
      bypass_in    = bypass_ff;
      d1_vld_in    = 1'b0;
      d1_tap_in    = iss_ff;
      d1_hit_in    = valid_ff[rd_addr_ff];
      d2_vld_in    = d1_vld_ff;
      prod_in      = operand * coef;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;

      if (csr_wr && (csr_paddr[2] == fir_pkg::REG_FILTER_ENABLE)) begin
         enable_in = csr_pwdata[0];
      end

      if (d2_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         fir_pkg::ST_IDLE: begin
            if (req_valid) begin
               smp_in    = req_sample_in;
               bypass_in = !enable_ff;
               state_in  = enable_ff ? fir_pkg::ST_WRITE : fir_pkg::ST_DONE;
            end
         end
         fir_pkg::ST_WRITE: begin
            // store newest sample, then read back starting at it
            ram_we          = 1'b1;
            valid_in[wp_ff] = 1'b1;
            rd_addr_in      = wp_ff;
            wp_in           = (wp_ff == LAST_TAP) ? '0 : wp_ff + PTR_W'(1);
            iss_in          = '0;
            acc_in          = '0;
            state_in        = fir_pkg::ST_MAC;
         end
         fir_pkg::ST_MAC: begin
            ram_re     = 1'b1;
            d1_vld_in  = 1'b1;
            rd_addr_in = (rd_addr_ff == '0) ? LAST_TAP : rd_addr_ff - PTR_W'(1);
            iss_in     = iss_ff + PTR_W'(1);
            if (iss_ff == LAST_TAP) begin
               state_in = fir_pkg::ST_DRAIN;
            end
         end
         fir_pkg::ST_DRAIN: begin
            if (!d1_vld_ff && !d2_vld_ff) begin
               state_in = fir_pkg::ST_DONE;
            end
         end
         fir_pkg::ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = bypass_ff ? smp_ff : sat_result;
               state_in     = fir_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fir_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b1;
         wp_ff        <= '0;
         valid_ff     <= '0;
         d1_vld_ff    <= 1'b0;
         d2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         enable_ff    <= enable_in;
         wp_ff        <= wp_in;
         valid_ff     <= valid_in;
         d1_vld_ff    <= d1_vld_in;
         d2_vld_ff    <= d2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and counters that the sequencer sets before use
   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      iss_ff      <= iss_in;
      smp_ff      <= smp_in;
      bypass_ff   <= bypass_in;
      d1_tap_ff   <= d1_tap_in;
      d1_hit_ff   <= d1_hit_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall      = (state_ff != fir_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

endmodule

`default_nettype wire

### rtl/fir_chk.sv
// fir_chk: port-level checks for fir_lowpass_27tap_core, bound to the top.
// Depends on fir_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module fir_chk (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_stall,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_stall,
   input wire logic signed [fir_pkg::SAMPLE_WIDTH-1:0] rsp_sample_out
);

   // a waiting word stays offered
   `FIR_ASSERT(a_rsp_valid_held, clock, reset, (rsp_valid && rsp_stall) |=> rsp_valid, "rsp_valid dropped while stalled")

   // and its value does not move
   `FIR_ASSERT_HOLD(a_rsp_data_held, clock, reset, rsp_valid && rsp_stall, rsp_sample_out, "rsp_sample_out changed while stalled")

   // one word in flight: an accepted word closes the input
   `FIR_ASSERT(a_one_in_flight, clock, reset, (req_valid && !req_stall) |=> req_stall, "input open right after accept")

   // results only come out of a busy core
   `FIR_ASSERT(a_rsp_from_busy, clock, reset, $rose(rsp_valid) |-> $past(req_stall), "result without a word in flight")

   // nothing offered right out of reset
   `FIR_ASSERT(a_reset_empty, clock, reset, $past(reset) |-> !rsp_valid, "rsp_valid set after reset")

endmodule

bind fir_lowpass_27tap_core fir_chk u_fir_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sample_out (rsp_sample_out)
);

`default_nettype wire

### verif/fir_lowpass_27tap_checker.sv
// Checker for fir_lowpass_27tap_core: tracks filter_enable writes on the csr port,
// predicts each output word with its own 27-tap history, compares rsp words in order.
// Depends on fir_pkg (port widths, register index).
module fir_lowpass_27tap_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_stall,
   input  logic signed [fir_pkg::SAMPLE_WIDTH-1:0] req_sample_in,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   input  logic signed [fir_pkg::SAMPLE_WIDTH-1:0] rsp_sample_out,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic                                    csr_pready,
   input  logic [fir_pkg::CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [fir_pkg::CSR_DATA_W-1:0]          csr_pwdata,
   output int                                      mismatches,
   output int                                      in_flight
);

   localparam int TAPS = 27;
   // Q1.15 taps, newest sample first
   localparam int COEF_Q15 [TAPS] = '{
      -272, 449, 266, -540, 55, -227, 1029, 745, -3927, 1699, 5616,
      -6594, -2766, 9228, -2766, -6594,
      5616, 1699, -3927, 745, 1029, -227, 55, -540, 266, 449, -272
   };
   localparam longint SAT_HI = 32767;
   localparam longint SAT_LO = -32768;
   localparam longint HALF_LSB = 64'sd16384;

   logic signed [15:0] history [TAPS];
   logic [4:0]         wr_ptr;
   logic               filter_enable;
   logic signed [15:0] expected_samples [$];

   // One filtered word: store, advance, convolve, round, clamp; else pass as is.
   function automatic logic signed [15:0] filter_step(input logic signed [15:0] x);
      longint acc;
      int     idx;
      if (!filter_enable) return x;
      history[wr_ptr] = x;
      wr_ptr = (wr_ptr == TAPS - 1) ? 5'd0 : wr_ptr + 5'd1;
      acc = 0;
      idx = wr_ptr;
      for (int i = 0; i < TAPS; i++) begin
         idx = (idx != 0) ? idx - 1 : TAPS - 1;
         acc += longint'(history[idx]) * longint'(COEF_Q15[i]);
      end
      acc = (acc + HALF_LSB) >>> 15;   // round half up
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      return acc[15:0];
   endfunction

   always @(posedge clock) begin : watch
      logic signed [15:0] want;
      if (reset) begin
         for (int i = 0; i < TAPS; i++) history[i] = '0;
         wr_ptr = '0;
         filter_enable = 1'b1;
         expected_samples.delete();
         mismatches = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[fir_pkg::CSR_ADDR_W-1:2] == fir_pkg::REG_FILTER_ENABLE)
            filter_enable = csr_pwdata[0];
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               $error("sample_out: no word expected, got %0d", rsp_sample_out);
               mismatches++;
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want) begin
                  $error("sample_out: expected %0d, got %0d", want, rsp_sample_out);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_samples.push_back(filter_step(req_sample_in));
      end
      in_flight <= expected_samples.size();
   end

endmodule

### verif/fir_lowpass_27tap_core_test.sv
// Top of the fir_lowpass_27tap_core bench: clock, reset, sample and csr stimulus,
// random back-pressure, verdict. Depends on fir_pkg, the core and fir_lowpass_27tap_checker.
module fir_lowpass_27tap_core_test;

   import fir_pkg::*;

   // byte addresses on the csr port; index 1 is unmapped and must be ignored
   localparam logic [CSR_ADDR_W-1:0] ADDR_FILTER_ENABLE = {REG_FILTER_ENABLE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED      = 3'd4;

   // Filtered directed words. Opens from the zeroed history with a rounding tie:
   // 16 four taps back (x 55) and -57 newest (x -272) sum to exactly half an LSB.
   localparam int DIRECTED_FILTERED [17] = '{
      16, 0, 0, 0, -57,
      32767, -32768, 0, 1, -1, 32767, 32767, -32768, -32768, 21845, -21846, 0
   };
   localparam int DIRECTED_BYPASS [7] = '{32767, -32768, 0, 1, -1, 21845, -21846};

   // sign of each tap, newest first; drives the saturating bursts
   localparam bit NEG_TAP [27] = '{
      1, 0, 0, 1, 0, 1, 0, 0, 1, 0, 0, 1, 1, 0, 1, 1, 0, 0, 1, 0, 0, 1, 0, 1, 0, 0, 1
   };

   // random phases: mode and word count, filter on at both ends
   localparam bit PHASE_FILTER [5] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   localparam int PHASE_WORDS  [5] = '{150, 50, 140, 40, 120};

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic signed [SAMPLE_WIDTH-1:0] req_sample_in = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out;
   logic                           csr_psel = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]          csr_paddr = '0;
   logic [CSR_DATA_W-1:0]          csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]          csr_prdata;
   logic                           csr_pready;

   int mismatches;
   int in_flight;

   // bench bookkeeping
   bit calm = 1'b0;        // no gaps and no new stalls while set
   bit filter_on = 1'b1;   // mirrors the last filter_enable written
   int stall_left = 0;
   int filtered_words = 0;
   int bypassed_words = 0;
   int reg_writes = 0;

   always #5 clock = ~clock;

   fir_lowpass_27tap_core uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   fir_lowpass_27tap_checker watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_sample_in  (req_sample_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sample_out (rsp_sample_out),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .mismatches     (mismatches),
      .in_flight      (in_flight)
   );

   // Idle stretch length: one of two random ranges, the long one picked now and then.
   function automatic int gap_len();
      if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   // Receiver back-pressure. A stall, once started, runs its full length so
   // finished words sit in the output register across every phase of a MAC pass.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
         rsp_stall <= 1'b1;
         stall_left <= gap_len() - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Offer one word, optionally after an idle gap, and return at the edge that
   // takes it. req_valid stays high so a following word goes back to back.
   task automatic send_word(input logic signed [SAMPLE_WIDTH-1:0] word);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 35) gap = gap_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         req_sample_in <= SAMPLE_WIDTH'($urandom());   // junk while idle
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (filter_on) filtered_words++;
      else bypassed_words++;
   endtask

   // Drop valid and wait for every predicted word to come back. The first
   // edge lets the checker count the word taken at the last accept.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
   endtask

   // APB write: setup then access. psel is left high so writes can chain;
   // csr_idle closes the transfer.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_FILTER_ENABLE) filter_on = data[0];
      reg_writes++;
   endtask

   task automatic csr_idle();
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Random bursts. Most are shaped to stress the datapath: full-range noise,
   // small values near zero, 27-word runs matched to the tap signs (drive the
   // sum past either rail), impulses and steps long enough to fill the history.
   task automatic run_random(input int words);
      int sent;
      int kind;
      int len;
      int amp;
      int level;
      bit flip;
      int burst [$];
      sent = 0;
      while (sent < words) begin
         burst.delete();
         calm = ($urandom_range(0, 5) == 0);
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: begin
               len = $urandom_range(1, 30);
               repeat (len) burst.push_back(int'($signed(16'($urandom()))));
            end
            4, 5: begin
               len = $urandom_range(1, 30);
               repeat (len) burst.push_back(int'($urandom_range(0, 512)) - 256);
            end
            6, 7: begin
               amp = $urandom_range(20000, 32767);
               flip = $urandom_range(0, 1);
               for (int k = 0; k < 27; k++) burst.push_back((NEG_TAP[k] ^ flip) ? -amp : amp);
            end
            8: begin
               case ($urandom_range(0, 2))
                  0: burst.push_back(32767);
                  1: burst.push_back(-32768);
                  default: burst.push_back(int'($signed(16'($urandom()))));
               endcase
               repeat (27) burst.push_back(0);
            end
            default: begin
               level = int'($signed(16'($urandom())));
               repeat (27) burst.push_back(level);
            end
         endcase
         foreach (burst[k]) send_word(SAMPLE_WIDTH'(burst[k]));
         sent += burst.size();
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed, filter on from reset: rounding tie, both rails, all bits.
      foreach (DIRECTED_FILTERED[k]) send_word(SAMPLE_WIDTH'(DIRECTED_FILTERED[k]));
      settle();

      // Bypass: raw word out, history untouched.
      write_reg(ADDR_FILTER_ENABLE, {$urandom() & 32'hFFFF_FFFE});
      csr_idle();
      foreach (DIRECTED_BYPASS[k]) send_word(SAMPLE_WIDTH'(DIRECTED_BYPASS[k]));
      settle();

      // Random phases, toggling the mode; unmapped index poked with junk that
      // could flip filter_enable if it were decoded.
      foreach (PHASE_FILTER[ph]) begin
         if (ph % 2 == 1)
            write_reg(ADDR_UNMAPPED, $urandom() | {31'd0, ~filter_on});
         write_reg(ADDR_FILTER_ENABLE, {$urandom() & 32'hFFFF_FFFE} | PHASE_FILTER[ph]);
         csr_idle();
         run_random(PHASE_WORDS[ph]);
         settle();
      end

      // tail: room for a late stray word
      repeat (3 * TAP_COUNT) @(posedge clock);

      $display("Covered %0d filtered and %0d bypassed words over %0d register writes,",
               filtered_words, bypassed_words, reg_writes);
      $display("with tie rounding, saturation runs and random back-pressure on both sides.");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog, several times the slowest legal run.
   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/fir_pkg.sv
rtl/fir_ram.sv
rtl/fir_lowpass_27tap_core.sv
rtl/fir_chk.sv
verif/fir_lowpass_27tap_checker.sv
verif/fir_lowpass_27tap_core_test.sv
